FILE: design/pgqs_pkg.sv
// Shared result codes for the prime gap query sieve.
package pgqs_pkg;

	localparam logic STAT_OK       = 1'b0;
	localparam logic STAT_NO_PRIME = 1'b1;

	typedef logic [15:0] gap_t;

endpackage

FILE: design/prime_gap_query_sieve.sv
// Prime gap query engine over a sieved composite bitmap held in one memory.
//
// Channels: query (query_valid/query_ready, value) in, result
// (result_valid/result_ready, gap_length, status) out, valid/ready on both.
// After reset the block clears its TABLE_SIZE x 1 bitmap one entry a cycle,
// then runs the sieve of Eratosthenes, one memory read per base tried and
// one write per multiple marked; query_ready stays low until the sieve is done.
// A query takes one memory read per bitmap entry visited, one a cycle through
// the single read port: the downward scan reads until it meets the lower prime,
// which for a prime (or 0, 1) is the value itself; for a composite the upward
// scan then reads on to the next prime, and gap is the distance between the
// surrounding primes. The result passes the finish state into the output
// register before the next query is taken. One query is in work at a
// time; query_ready is high only while the engine is waiting for a query.
// The result sits in an output register, so the next query is taken and
// scanned while a stalled receiver still holds the previous result; the
// engine then waits with its new result until the output register frees up.
// status is 1 when no prime lies above the value inside the table, or the
// value is at or beyond TABLE_SIZE; gap_length is 0 then and for primes.
module prime_gap_query_sieve #(
	parameter int unsigned TABLE_SIZE = 65536
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              query_valid,
	output logic              query_ready,
	input  logic [15:0]       value,
	output logic              result_valid,
	input  logic              result_ready,
	output pgqs_pkg::gap_t    gap_length,
	output logic              status
);
	import pgqs_pkg::*;

	localparam int AW = $clog2(TABLE_SIZE);
	localparam int CW = AW + 1;
	localparam logic [CW-1:0] TSZ  = CW'(TABLE_SIZE);
	localparam logic [CW-1:0] TLAST = CW'(TABLE_SIZE - 1);

	localparam logic [2:0] S_CLEAR    = 3'd0;
	localparam logic [2:0] S_BASE_RD  = 3'd1;
	localparam logic [2:0] S_BASE_CHK = 3'd2;
	localparam logic [2:0] S_MARK     = 3'd3;
	localparam logic [2:0] S_IDLE     = 3'd4;
	localparam logic [2:0] S_DOWN     = 3'd5;
	localparam logic [2:0] S_UP       = 3'd6;
	localparam logic [2:0] S_FIN      = 3'd7;

	logic          comp_map [TABLE_SIZE];
	logic          rdata_q;
	logic          we;
	logic          wdata;
	logic [AW-1:0] waddr;
	logic          re;
	logic [AW-1:0] raddr;

	logic [2:0]    state_q;
	logic [CW-1:0] base_q;
	logic [CW-1:0] sq_q;
	logic [CW-1:0] mult_q;
	logic [CW-1:0] mult_next;
	logic [CW-1:0] v_q;
	logic [CW-1:0] ptr_q;
	logic [AW-1:0] addr_s1;
	logic [AW-1:0] lo_q;
	gap_t          res_gap_q;
	logic          res_stat_q;
	logic          out_valid_q;
	gap_t          out_gap_q;
	logic          out_stat_q;

	logic [31:0]   v32;
	logic          v_in_range;
	logic [31:0]   gap32;
	logic          accept;
	logic          out_free;

	assign v32        = 32'(value);
	assign v_in_range = v32 < 32'(TABLE_SIZE);
	assign gap32      = 32'(addr_s1) - 32'(lo_q);
	assign accept     = query_valid && query_ready;
	assign out_free   = !out_valid_q || result_ready;
	assign mult_next  = mult_q + base_q;

	assign query_ready  = (state_q == S_IDLE);
	assign result_valid = out_valid_q;
	assign gap_length   = out_gap_q;
	assign status       = out_stat_q;

	// Memory port control.
	always_comb begin
		we    = (state_q == S_CLEAR) || (state_q == S_MARK);
		wdata = (state_q == S_MARK);
		waddr = mult_q[AW-1:0];
		re    = 1'b0;
		raddr = ptr_q[AW-1:0];
		unique case (state_q)
			S_BASE_RD: begin
				re    = sq_q < TSZ;
				raddr = base_q[AW-1:0];
			end
			S_IDLE: begin
				re    = accept && v_in_range;
				raddr = v32[AW-1:0];
			end
			S_DOWN: begin
				if (!rdata_q) begin
					// lower prime found: start the upward scan just above the value
					re    = (CW'(addr_s1) != v_q) && (v_q != TLAST);
					raddr = AW'(v_q + CW'(1));
				end else begin
					re    = 1'b1;
					raddr = ptr_q[AW-1:0];
				end
			end
			S_UP: begin
				re    = rdata_q && (CW'(addr_s1) != TLAST);
				raddr = ptr_q[AW-1:0];
			end
			default: begin
				re = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			comp_map[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= comp_map[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			base_q      <= CW'(2);
			sq_q        <= CW'(4);
			mult_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					mult_q <= mult_q + CW'(1);
					if (mult_q == TLAST) begin
						state_q <= S_BASE_RD;
					end
				end
				S_BASE_RD: begin
					state_q <= (sq_q < TSZ) ? S_BASE_CHK : S_IDLE;
				end
				S_BASE_CHK: begin
					if (rdata_q) begin
						base_q  <= base_q + CW'(1);
						sq_q    <= sq_q + (base_q << 1) + CW'(1);
						state_q <= S_BASE_RD;
					end else begin
						mult_q  <= sq_q;
						state_q <= S_MARK;
					end
				end
				S_MARK: begin
					mult_q <= mult_next;
					if (mult_next >= TSZ) begin
						base_q  <= base_q + CW'(1);
						sq_q    <= sq_q + (base_q << 1) + CW'(1);
						state_q <= S_BASE_RD;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (v_in_range) begin
							v_q     <= v32[CW-1:0];
							addr_s1 <= v32[AW-1:0];
							ptr_q   <= v32[CW-1:0] - CW'(1);
							state_q <= S_DOWN;
						end else begin
							res_gap_q  <= '0;
							res_stat_q <= STAT_NO_PRIME;
							state_q    <= S_FIN;
						end
					end
				end
				S_DOWN: begin
					if (!rdata_q) begin
						lo_q <= addr_s1;
						if (CW'(addr_s1) == v_q) begin
							res_gap_q  <= '0;
							res_stat_q <= STAT_OK;
							state_q    <= S_FIN;
						end else if (v_q == TLAST) begin
							res_gap_q  <= '0;
							res_stat_q <= STAT_NO_PRIME;
							state_q    <= S_FIN;
						end else begin
							addr_s1 <= AW'(v_q + CW'(1));
							ptr_q   <= v_q + CW'(2);
							state_q <= S_UP;
						end
					end else begin
						addr_s1 <= ptr_q[AW-1:0];
						ptr_q   <= ptr_q - CW'(1);
					end
				end
				S_UP: begin
					if (!rdata_q) begin
						res_gap_q  <= gap32[15:0];
						res_stat_q <= STAT_OK;
						state_q    <= S_FIN;
					end else if (CW'(addr_s1) == TLAST) begin
						res_gap_q  <= '0;
						res_stat_q <= STAT_NO_PRIME;
						state_q    <= S_FIN;
					end else begin
						addr_s1 <= ptr_q[AW-1:0];
						ptr_q   <= ptr_q + CW'(1);
					end
				end
				S_FIN: begin
					// hold the result until the output register frees up
					if (out_free) begin
						out_gap_q   <= res_gap_q;
						out_stat_q  <= res_stat_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
		end
	end

	a_square_tracks_base: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BASE_RD) |->
		((2*CW)'(sq_q) == (2*CW)'(base_q) * (2*CW)'(base_q)))
		else $error("sieve square out of step with base");

	a_mark_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MARK) |-> (mult_q < TSZ && mult_q >= sq_q))
		else $error("sieve marks outside its range");

	a_down_below_value: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DOWN) |-> (CW'(addr_s1) <= v_q))
		else $error("downward scan passed the query value");

	a_up_above_low: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UP) |-> (addr_s1 > lo_q && CW'(addr_s1) > v_q))
		else $error("upward scan not above the lower prime");

	a_one_query: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !query_ready)
		else $error("second query taken while one is in work");

	a_fin_loads_output: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && out_free) |=> (out_valid_q && state_q == S_IDLE))
		else $error("finished result not moved to the output register");

endmodule

FILE: sim/tb_prime_gap_query_sieve.sv
// Self-checking testbench for the prime gap query sieve: random and directed queries.
module tb_prime_gap_query_sieve;
	timeunit 1ns;
	timeprecision 1ps;

	import pgqs_pkg::*;

	localparam int unsigned TBL = 65536;
	localparam int unsigned HOLD_CYCLES = 500;

	typedef struct packed {
		gap_t gap;
		logic stat;
	} gap_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        query_valid = 1'b0;
	logic        query_ready;
	logic [15:0] value = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	gap_t        gap_length;
	logic        status;

	bit          composite_map [TBL];
	logic [15:0] pending_values [$];
	gap_result_t expected_gaps [$];
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned queued_count = 0;
	int unsigned accepted_count = 0;
	int unsigned err_count = 0;
	logic        rx_hold = 1'b0;
	event        hold_go;

	prime_gap_query_sieve dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.query_valid  (query_valid),
		.query_ready  (query_ready),
		.value        (value),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.gap_length   (gap_length),
		.status       (status)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic void build_composite_map();
		int unsigned base, m;
		for (int unsigned i = 0; i < TBL; i++)
			composite_map[i] = 1'b0;
		for (base = 2; base * base < TBL; base++) begin
			if (!composite_map[base]) begin
				for (m = base * base; m < TBL; m += base)
					composite_map[m] = 1'b1;
			end
		end
	endfunction

	function automatic gap_result_t predict_gap(logic [15:0] v);
		int unsigned lo, hi;
		gap_result_t r;
		r.gap = '0;
		r.stat = STAT_OK;
		if (32'(v) >= TBL) begin
			r.stat = STAT_NO_PRIME;
			return r;
		end
		if (!composite_map[v])
			return r;
		lo = 32'(v);
		while (lo > 0 && composite_map[lo])
			lo--;
		hi = 32'(v);
		while (hi < TBL && composite_map[hi])
			hi++;
		if (hi >= TBL)
			r.stat = STAT_NO_PRIME;
		else
			r.gap = gap_t'(hi - lo);
		return r;
	endfunction

	function automatic logic [15:0] pick_value();
		logic [15:0] v;
		case ($urandom_range(3))
			0: v = 16'($urandom_range(400));
			1: v = 16'($urandom_range(65535, 65300));
			default: v = 16'($urandom_range(65535));
		endcase
		return v;
	endfunction

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		$display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		err_count++;
	endtask

	task automatic queue_value(logic [15:0] v);
		pending_values.push_back(v);
		queued_count++;
	endtask

	task automatic queue_random(int unsigned n);
		repeat (n) queue_value(pick_value());
	endtask

	task automatic wait_drained();
		while (accepted_count < queued_count || expected_gaps.size() > 0)
			@(posedge clk);
	endtask

	// sender: offer the next item once the current one is taken
	always @(posedge clk) begin
		if (arst_n && (!query_valid || query_ready)) begin
			if (pending_values.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				value <= pending_values.pop_front();
				query_valid <= 1'b1;
			end else begin
				query_valid <= 1'b0;
			end
		end
	end

	// receiver and checker
	always @(posedge clk) begin
		gap_result_t want;
		if (arst_n) begin
			if (query_valid && query_ready) begin
				expected_gaps.push_back(predict_gap(value));
				accepted_count++;
			end
			if (result_valid && result_ready) begin
				if (expected_gaps.size() == 0) begin
					report_mismatch("unexpected result, gap_length", 32'(gap_length), 0);
				end else begin
					want = expected_gaps.pop_front();
					if (gap_length !== want.gap)
						report_mismatch("gap_length", 32'(gap_length), 32'(want.gap));
					if (status !== want.stat)
						report_mismatch("status", 32'(status), 32'(want.stat));
				end
			end
			result_ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// long receiver hold-off, counted here
	initial begin
		forever begin
			@(hold_go);
			rx_hold <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			rx_hold <= 1'b0;
		end
	end

	initial begin
		#(24_000_000);
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		logic [15:0] directed [] = '{
			16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd9, 16'd25, 16'd49,
			16'd255, 16'd256, 16'd1328, 16'd4096, 16'd31398, 16'd32768,
			16'd65519, 16'd65520, 16'd65521, 16'd65522, 16'd65534, 16'd65535,
			16'h5555, 16'hAAAA
		};
		build_composite_map();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// edges, primes, small values, widest gaps, top of table with no prime above
		foreach (directed[i])
			queue_value(directed[i]);
		wait_drained();

		queue_random(200);
		wait_drained();

		send_idle_pct = 60;
		queue_random(200);
		wait_drained();

		send_idle_pct = 0;
		recv_stall_pct = 60;
		queue_random(200);
		wait_drained();

		send_idle_pct = 32;
		recv_stall_pct = 32;
		queue_random(150);
		wait_drained();

		// fill the block behind a stalled receiver
		send_idle_pct = 0;
		recv_stall_pct = 0;
		queue_random(40);
		@(posedge clk);
		-> hold_go;
		wait_drained();

		repeat (200) @(posedge clk);
		if (err_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
